// File: rtl/gof_pkg.sv
package gof_pkg;

    // Default widths of the coordinate fields.
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Curve sampling.
    localparam int SEG_BITS  = 6;
    localparam int MAX_SEG   = 61;
    localparam int RESET_SEG = 8;
    // Widest divisor: MAX_SEG cubed fits in 18 bits.
    localparam int D_BITS    = 18;

    // Buffer of pending outline points.
    localparam int PEND_DEPTH = 4;
    localparam int PIDX_BITS  = $clog2(PEND_DEPTH);
    localparam int CNT_BITS   = $clog2(PEND_DEPTH + 1);

    // Queues between the parts.
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Configuration port.
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam logic REG_IDX_SEGMENTS = 1'b0;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_CONIC = 2'd1,
        KIND_CUBIC = 2'd2
    } t_kind;

    // Control part of one job handed from the front end to the back end.
    typedef struct packed {
        logic                curve_en;
        t_kind               curve_kind;
        logic [CNT_BITS-1:0] ecnt;
        logic                close;
    } t_job_ctl;

endpackage

// File: rtl/glyph_outline_flattener.sv
// Glyph outline flattener. Outline points enter through a queue-style push port and polyline
// vertices leave through a queue-style pop port; each vertex carries a flag on the repeated
// first vertex that closes a contour and a flag on the last vertex caused by an input point.
// The front end takes one point per cycle while its job queue has room and may turn it into a
// job; the back end works one job at a time: it takes the job from the queue, then emits the
// curve samples, the straight-line vertices or flushed points and the closing vertex. Each
// sample goes through a shared multiply-accumulate and a restoring divider that resolves one
// quotient bit per cycle. segments_per_curve is written through the APB-style port at byte
// address 0 and should only be changed while the block is idle.
module glyph_outline_flattener
    import gof_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Point queue.
    input  logic                            push,
    output logic                            full,
    input  logic [COORD_BITS-1:0]           i_point_x,
    input  logic [COORD_BITS-1:0]           i_point_y,
    input  logic [1:0]                      i_point_kind,
    input  logic                            i_ends_contour,
    // Vertex queue.
    output logic                            empty,
    input  logic                            pop,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_vertex_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_vertex_y,
    output logic                            o_closes_contour,
    output logic                            o_last_of_run,
    // Configuration.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_BITS-1:0]            paddr,
    input  logic [DATA_BITS-1:0]            pwdata,
    output logic [DATA_BITS-1:0]            prdata,
    output logic                            pready
);

    localparam int OUT  = COORD_BITS + FRAC_BITS;
    localparam int CTLW = $bits(t_job_ctl);
    localparam int JW   = CTLW + 4 * PEND_DEPTH * OUT;
    localparam int OW   = 2 * OUT + 2;

    logic [SEG_BITS-1:0] r_segments;
    logic                accept;

    t_job_ctl            f_ctl, b_ctl;
    logic                f_valid;
    logic [OUT-1:0]      f_cpx [PEND_DEPTH];
    logic [OUT-1:0]      f_cpy [PEND_DEPTH];
    logic [OUT-1:0]      f_ex  [PEND_DEPTH];
    logic [OUT-1:0]      f_ey  [PEND_DEPTH];
    logic [OUT-1:0]      b_cpx [PEND_DEPTH];
    logic [OUT-1:0]      b_cpy [PEND_DEPTH];
    logic [OUT-1:0]      b_ex  [PEND_DEPTH];
    logic [OUT-1:0]      b_ey  [PEND_DEPTH];
    logic [JW-1:0]       job_wdata, job_rdata;
    logic                job_full, job_empty, job_pop;

    logic                out_push, out_full, out_closes, out_last;
    logic [OUT-1:0]      out_x, out_y;
    logic [OW-1:0]       out_rdata;

    // The register file holds a single register; writes to any other slot are ignored.
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_BITS-1] == REG_IDX_SEGMENTS) ?
                    {{(DATA_BITS - SEG_BITS){1'b0}}, r_segments} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= SEG_BITS'(RESET_SEG);
        end else if (psel && penable && pwrite && pready &&
                     (paddr[ADDR_BITS-1] == REG_IDX_SEGMENTS)) begin
            r_segments <= pwdata[SEG_BITS-1:0];
        end
    end

    // A point is taken whenever the job queue has room, even if it yields no job.
    assign full   = job_full;
    assign accept = push && !job_full;

    gof_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_kind   (i_point_kind),
        .i_ends_contour (i_ends_contour),
        .o_job_valid    (f_valid),
        .o_job_ctl      (f_ctl),
        .o_cpx          (f_cpx),
        .o_cpy          (f_cpy),
        .o_ex           (f_ex),
        .o_ey           (f_ey)
    );

    // Job layout: control on top, then the emitted points and the curve points.
    always_comb begin
        job_wdata[JW-1 -: CTLW] = f_ctl;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            job_wdata[i * OUT +: OUT]                    = f_cpx[i];
            job_wdata[(PEND_DEPTH + i) * OUT +: OUT]     = f_cpy[i];
            job_wdata[(2 * PEND_DEPTH + i) * OUT +: OUT] = f_ex[i];
            job_wdata[(3 * PEND_DEPTH + i) * OUT +: OUT] = f_ey[i];
        end
    end

    gof_fifo #(
        .WIDTH (JW),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && f_valid),
        .i_data  (job_wdata),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_rdata),
        .o_empty (job_empty)
    );

    always_comb begin
        b_ctl = t_job_ctl'(job_rdata[JW-1 -: CTLW]);
        for (int i = 0; i < PEND_DEPTH; i++) begin
            b_cpx[i] = job_rdata[i * OUT +: OUT];
            b_cpy[i] = job_rdata[(PEND_DEPTH + i) * OUT +: OUT];
            b_ex[i]  = job_rdata[(2 * PEND_DEPTH + i) * OUT +: OUT];
            b_ey[i]  = job_rdata[(3 * PEND_DEPTH + i) * OUT +: OUT];
        end
    end

    gof_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_segments   (r_segments),
        .i_job_avail  (!job_empty),
        .i_job_ctl    (b_ctl),
        .i_cpx        (b_cpx),
        .i_cpy        (b_cpy),
        .i_ex         (b_ex),
        .i_ey         (b_ey),
        .o_job_pop    (job_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out_x      (out_x),
        .o_out_y      (out_y),
        .o_out_closes (out_closes),
        .o_out_last   (out_last)
    );

    // The vertex queue decouples the engine from the consumer.
    gof_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_vertex_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  ({out_x, out_y, out_closes, out_last}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_empty (empty)
    );

    assign o_vertex_x       = out_rdata[OW-1 -: OUT];
    assign o_vertex_y       = out_rdata[OUT+1 -: OUT];
    assign o_closes_contour = out_rdata[1];
    assign o_last_of_run    = out_rdata[0];

endmodule

// File: rtl/gof_fifo.sv
module gof_fifo
    import gof_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CW-1:0]       r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/gof_front.sv
module gof_front
    import gof_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int OUT = COORD_BITS + FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic [1:0]            i_point_kind,
    input  logic                  i_ends_contour,
    output logic                  o_job_valid,
    output t_job_ctl              o_job_ctl,
    output logic [OUT-1:0]        o_cpx [PEND_DEPTH],
    output logic [OUT-1:0]        o_cpy [PEND_DEPTH],
    output logic [OUT-1:0]        o_ex  [PEND_DEPTH],
    output logic [OUT-1:0]        o_ey  [PEND_DEPTH]
);

    logic [OUT-1:0]      r_pend_x [PEND_DEPTH];
    logic [OUT-1:0]      r_pend_y [PEND_DEPTH];
    logic [CNT_BITS-1:0] r_cnt;
    t_kind               r_seg;

    logic [OUT-1:0]      n_pend_x [PEND_DEPTH];
    logic [OUT-1:0]      n_pend_y [PEND_DEPTH];
    logic [CNT_BITS-1:0] n_cnt;
    t_kind               n_seg;

    always_comb begin
        logic [OUT-1:0]       vx, vy, mx, my, px, py;
        logic [OUT:0]         sumx, sumy;
        logic [PIDX_BITS-1:0] b, e;
        logic                 is_conic, is_cubic, close_curve;

        n_pend_x  = r_pend_x;
        n_pend_y  = r_pend_y;
        n_cnt     = r_cnt;
        n_seg     = r_seg;
        o_job_ctl = '0;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            o_cpx[i] = '0;
            o_cpy[i] = '0;
            o_ex[i]  = '0;
            o_ey[i]  = '0;
        end
        e = '0;

        vx = {i_point_x, {FRAC_BITS{1'b0}}};
        vy = {i_point_y, {FRAC_BITS{1'b0}}};
        is_conic = (i_point_kind == KIND_CONIC);
        is_cubic = (i_point_kind == KIND_CUBIC);

        // Implied on-curve midpoint against the newest pending point.
        b    = (r_cnt == '0) ? '0 : PIDX_BITS'(r_cnt - 1'b1);
        sumx = {r_pend_x[b][OUT-1], r_pend_x[b]} + {vx[OUT-1], vx};
        sumy = {r_pend_y[b][OUT-1], r_pend_y[b]} + {vy[OUT-1], vy};
        mx   = sumx[OUT:1];
        my   = sumy[OUT:1];

        close_curve = (is_conic && (r_seg == KIND_CONIC)) ||
                      (!is_conic && !is_cubic && (r_seg != KIND_LINE));
        px = is_conic ? mx : vx;
        py = is_conic ? my : vy;

        if (close_curve) begin
            if (n_cnt < CNT_BITS'(PEND_DEPTH)) begin
                n_pend_x[n_cnt[PIDX_BITS-1:0]] = px;
                n_pend_y[n_cnt[PIDX_BITS-1:0]] = py;
                n_cnt = n_cnt + 1'b1;
            end
            for (int i = 0; i < PEND_DEPTH; i++) begin
                e = (CNT_BITS'(i) < n_cnt) ? PIDX_BITS'(i) : PIDX_BITS'(n_cnt - 1'b1);
                o_cpx[i] = (n_cnt == '0) ? '0 : n_pend_x[e];
                o_cpy[i] = (n_cnt == '0) ? '0 : n_pend_y[e];
            end
            // The end point of this curve starts the next one.
            n_pend_x[0] = px;
            n_pend_y[0] = py;
            n_cnt = CNT_BITS'(1);
            o_job_ctl.curve_en   = 1'b1;
            o_job_ctl.curve_kind = is_conic ? KIND_CONIC : r_seg;
        end

        if (is_conic || is_cubic) begin
            if (n_cnt < CNT_BITS'(PEND_DEPTH)) begin
                n_pend_x[n_cnt[PIDX_BITS-1:0]] = vx;
                n_pend_y[n_cnt[PIDX_BITS-1:0]] = vy;
                n_cnt = n_cnt + 1'b1;
            end
            n_seg = is_conic ? KIND_CONIC : KIND_CUBIC;
        end else if (close_curve) begin
            n_seg = KIND_LINE;
        end else begin
            // A straight-line vertex leaves one point late.
            if (n_cnt == CNT_BITS'(1)) begin
                o_ex[0] = n_pend_x[0];
                o_ey[0] = n_pend_y[0];
                o_job_ctl.ecnt = CNT_BITS'(1);
                n_cnt = '0;
            end
            if (n_cnt < CNT_BITS'(PEND_DEPTH)) begin
                n_pend_x[n_cnt[PIDX_BITS-1:0]] = vx;
                n_pend_y[n_cnt[PIDX_BITS-1:0]] = vy;
                n_cnt = n_cnt + 1'b1;
            end
        end

        if (i_ends_contour) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
                if ((CNT_BITS'(i) < n_cnt) && (o_job_ctl.ecnt < CNT_BITS'(PEND_DEPTH))) begin
                    o_ex[o_job_ctl.ecnt[PIDX_BITS-1:0]] = n_pend_x[i];
                    o_ey[o_job_ctl.ecnt[PIDX_BITS-1:0]] = n_pend_y[i];
                    o_job_ctl.ecnt = o_job_ctl.ecnt + 1'b1;
                end
            end
            n_cnt = '0;
            o_job_ctl.close = 1'b1;
            n_seg = KIND_LINE;
        end
    end

    assign o_job_valid = o_job_ctl.curve_en || (o_job_ctl.ecnt != '0) || o_job_ctl.close;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend_x <= n_pend_x;
            r_pend_y <= n_pend_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_seg <= KIND_LINE;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
            r_seg <= n_seg;
        end
    end

endmodule

// File: rtl/gof_back.sv
module gof_back
    import gof_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int OUT = COORD_BITS + FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SEG_BITS-1:0] i_segments,
    input  logic                i_job_avail,
    input  t_job_ctl            i_job_ctl,
    input  logic [OUT-1:0]      i_cpx [PEND_DEPTH],
    input  logic [OUT-1:0]      i_cpy [PEND_DEPTH],
    input  logic [OUT-1:0]      i_ex  [PEND_DEPTH],
    input  logic [OUT-1:0]      i_ey  [PEND_DEPTH],
    output logic                o_job_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output logic [OUT-1:0]      o_out_x,
    output logic [OUT-1:0]      o_out_y,
    output logic                o_out_closes,
    output logic                o_out_last
);

    localparam int SW    = OUT + D_BITS + 1;
    localparam int BIT_W = $clog2(OUT);
    localparam int SQ    = 2 * SEG_BITS;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_DSET  = 11'b000_0000_0010,
        ST_DCUBE = 11'b000_0000_0100,
        ST_W1    = 11'b000_0000_1000,
        ST_W2    = 11'b000_0001_0000,
        ST_MAC   = 11'b000_0010_0000,
        ST_BIAS  = 11'b000_0100_0000,
        ST_DIV   = 11'b000_1000_0000,
        ST_CEMIT = 11'b001_0000_0000,
        ST_EMIT  = 11'b010_0000_0000,
        ST_CLOSE = 11'b100_0000_0000
    } t_state;

    t_state               r_state;
    t_job_ctl             r_ctl;
    logic [OUT-1:0]       r_cpx [PEND_DEPTH];
    logic [OUT-1:0]       r_cpy [PEND_DEPTH];
    logic [OUT-1:0]       r_ex  [PEND_DEPTH];
    logic [OUT-1:0]       r_ey  [PEND_DEPTH];
    logic [SEG_BITS-1:0]  r_n, r_k, r_a;
    logic [SQ-1:0]        r_n2, r_a2, r_k2, r_ka;
    logic [D_BITS-1:0]    r_d;
    logic [D_BITS-1:0]    r_w [PEND_DEPTH];
    logic [PIDX_BITS-1:0] r_i;
    logic [SW-1:0]        r_acc_x, r_acc_y;
    logic [SW-1:0]        r_rem_x, r_rem_y, r_dsh;
    logic [OUT-1:0]       r_q_x, r_q_y;
    logic [BIT_W-1:0]     r_bit;
    logic [CNT_BITS-1:0]  r_eidx;
    logic [OUT-1:0]       r_first_x, r_first_y;
    logic                 r_first_seen;

    logic [SEG_BITS-1:0]  seg_clamped;
    logic [SEG_BITS-1:0]  a_now;
    logic [D_BITS-1:0]    n_w [PEND_DEPTH];
    logic [SW-1:0]        mul_x, mul_y, bias;
    logic                 ge_x, ge_y;
    logic                 curve_done, emit_done, push_ok;
    logic [OUT-1:0]       q_x, q_y;

    // Zero segments means one, and the count saturates at the maximum.
    assign seg_clamped = (i_segments == '0) ? SEG_BITS'(1) :
                         (i_segments > SEG_BITS'(MAX_SEG)) ? SEG_BITS'(MAX_SEG) : i_segments;
    assign a_now = r_n - r_k;

    // Bernstein weights of the current step.
    always_comb begin
        logic [D_BITS-1:0] a2a, kaa, k2a, k2k;
        a2a = D_BITS'({{(D_BITS - SQ){1'b0}}, r_a2} * {{(D_BITS - SEG_BITS){1'b0}}, r_a});
        kaa = D_BITS'({{(D_BITS - SQ){1'b0}}, r_ka} * {{(D_BITS - SEG_BITS){1'b0}}, r_a});
        k2a = D_BITS'({{(D_BITS - SQ){1'b0}}, r_k2} * {{(D_BITS - SEG_BITS){1'b0}}, r_a});
        k2k = D_BITS'({{(D_BITS - SQ){1'b0}}, r_k2} * {{(D_BITS - SEG_BITS){1'b0}}, r_k});
        if (r_ctl.curve_kind == KIND_CONIC) begin
            n_w[0] = D_BITS'(r_a2);
            n_w[1] = D_BITS'({r_ka, 1'b0});
            n_w[2] = D_BITS'(r_k2);
            n_w[3] = '0;
        end else begin
            n_w[0] = a2a;
            n_w[1] = kaa + {kaa[D_BITS-2:0], 1'b0};
            n_w[2] = k2a + {k2a[D_BITS-2:0], 1'b0};
            n_w[3] = k2k;
        end
    end

    // An unsigned weight times a signed coordinate; the product just fills SW bits.
    assign mul_x = $signed({1'b0, r_w[r_i]}) * $signed(r_cpx[r_i]);
    assign mul_y = $signed({1'b0, r_w[r_i]}) * $signed(r_cpy[r_i]);

    // Rounding half and an offset that makes the dividend non-negative.
    assign bias = SW'(r_d >> 1) + (SW'(r_d) << (OUT - 1));

    assign ge_x = (r_rem_x >= r_dsh);
    assign ge_y = (r_rem_y >= r_dsh);

    // Removing the offset again is a flip of the top quotient bit.
    assign q_x = {~r_q_x[OUT-1], r_q_x[OUT-2:0]};
    assign q_y = {~r_q_y[OUT-1], r_q_y[OUT-2:0]};

    assign curve_done = (r_k == r_n - 1'b1);
    assign emit_done  = (r_eidx == r_ctl.ecnt - 1'b1);

    assign o_job_pop = (r_state == ST_IDLE) && i_job_avail;
    assign push_ok   = !i_out_full;

    always_comb begin
        o_out_push   = 1'b0;
        o_out_x      = q_x;
        o_out_y      = q_y;
        o_out_closes = 1'b0;
        o_out_last   = 1'b0;
        unique case (r_state)
            ST_CEMIT: begin
                o_out_push = push_ok;
                o_out_last = curve_done && (r_ctl.ecnt == '0) && !r_ctl.close;
            end
            ST_EMIT: begin
                o_out_push = push_ok;
                o_out_x    = r_ex[r_eidx[PIDX_BITS-1:0]];
                o_out_y    = r_ey[r_eidx[PIDX_BITS-1:0]];
                o_out_last = emit_done && !r_ctl.close;
            end
            ST_CLOSE: begin
                o_out_push   = push_ok;
                o_out_x      = r_first_seen ? r_first_x : '0;
                o_out_y      = r_first_seen ? r_first_y : '0;
                o_out_closes = 1'b1;
                o_out_last   = 1'b1;
            end
            default: begin
                o_out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_first_seen <= 1'b0;
        end else begin
            if (o_out_push && !o_out_closes && !r_first_seen) begin
                r_first_seen <= 1'b1;
                r_first_x    <= o_out_x;
                r_first_y    <= o_out_y;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_avail) begin
                        r_ctl  <= i_job_ctl;
                        r_cpx  <= i_cpx;
                        r_cpy  <= i_cpy;
                        r_ex   <= i_ex;
                        r_ey   <= i_ey;
                        r_eidx <= '0;
                        if (i_job_ctl.curve_en) begin
                            r_state <= ST_DSET;
                        end else if (i_job_ctl.ecnt != '0) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_CLOSE;
                        end
                    end
                end
                ST_DSET: begin
                    r_n     <= seg_clamped;
                    r_n2    <= {{SEG_BITS{1'b0}}, seg_clamped} * {{SEG_BITS{1'b0}}, seg_clamped};
                    r_k     <= '0;
                    r_state <= ST_DCUBE;
                end
                ST_DCUBE: begin
                    if (r_ctl.curve_kind == KIND_CONIC) begin
                        r_d <= D_BITS'(r_n2);
                    end else begin
                        r_d <= D_BITS'({{(D_BITS - SQ){1'b0}}, r_n2} *
                                       {{(D_BITS - SEG_BITS){1'b0}}, r_n});
                    end
                    r_state <= ST_W1;
                end
                ST_W1: begin
                    r_a     <= a_now;
                    r_a2    <= {{SEG_BITS{1'b0}}, a_now} * {{SEG_BITS{1'b0}}, a_now};
                    r_k2    <= {{SEG_BITS{1'b0}}, r_k} * {{SEG_BITS{1'b0}}, r_k};
                    r_ka    <= {{SEG_BITS{1'b0}}, r_k} * {{SEG_BITS{1'b0}}, a_now};
                    r_state <= ST_W2;
                end
                ST_W2: begin
                    r_w     <= n_w;
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_i     <= '0;
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    r_acc_x <= r_acc_x + mul_x;
                    r_acc_y <= r_acc_y + mul_y;
                    r_i     <= r_i + 1'b1;
                    if (r_i == PIDX_BITS'(PEND_DEPTH - 1)) begin
                        r_state <= ST_BIAS;
                    end
                end
                ST_BIAS: begin
                    r_rem_x <= r_acc_x + bias;
                    r_rem_y <= r_acc_y + bias;
                    r_dsh   <= SW'(r_d) << (OUT - 1);
                    r_bit   <= BIT_W'(OUT - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (ge_x) begin
                        r_rem_x <= r_rem_x - r_dsh;
                    end
                    if (ge_y) begin
                        r_rem_y <= r_rem_y - r_dsh;
                    end
                    r_q_x <= {r_q_x[OUT-2:0], ge_x};
                    r_q_y <= {r_q_y[OUT-2:0], ge_y};
                    r_dsh <= r_dsh >> 1;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= ST_CEMIT;
                    end
                end
                ST_CEMIT: begin
                    if (push_ok) begin
                        r_k <= r_k + 1'b1;
                        if (!curve_done) begin
                            r_state <= ST_W1;
                        end else if (r_ctl.ecnt != '0) begin
                            r_state <= ST_EMIT;
                        end else if (r_ctl.close) begin
                            r_state <= ST_CLOSE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT: begin
                    if (push_ok) begin
                        r_eidx <= r_eidx + 1'b1;
                        if (emit_done) begin
                            r_state <= r_ctl.close ? ST_CLOSE : ST_IDLE;
                        end
                    end
                end
                ST_CLOSE: begin
                    if (push_ok) begin
                        r_first_seen <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_pop_starts_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state != ST_IDLE))
        else $error("job taken from the queue but the engine stayed idle");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_out_closes) |-> o_out_last)
        else $error("closing vertex not flagged as the last of its run");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CEMIT) |-> (r_k < r_n))
        else $error("curve step beyond the segment count");

    a_div_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_bit == '0)) |=> (r_state == ST_CEMIT))
        else $error("divider did not hand over after its last quotient bit");

endmodule
